// ===== design/e2c_pkg.sv =====
package e2c_pkg;

  // Port widths
  localparam int unsigned EPOCH_W     = 31;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 56;
  localparam int unsigned TZ_W        = 17;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 17;

  // Result field widths
  localparam int unsigned YEAR_W  = 11;
  localparam int unsigned DOY_W   = 9;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DOM_W   = 5;
  localparam int unsigned WDAY_W  = 3;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned SEC_W   = 6;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TZ_WEST    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DST_ENABLE = 1'b1;

  // Time constants
  localparam int unsigned SECS_HOUR = 3600;

  // Seconds to days: the low 7 bits of 86400 are zero, the rest is 675
  localparam int unsigned DAY_SHIFT = 7;
  localparam int unsigned DAY_DIV   = 675;
  localparam int unsigned DAY_NUM_W = 25;
  localparam int unsigned DAYS_W    = 15;
  localparam int unsigned SOD_W     = 17;

  // Days to four-year cycles
  localparam int unsigned CYCLE_DAYS = 1461;
  localparam int unsigned CYC_W      = 5;

  // Weekday: day 0 was a Thursday
  localparam int unsigned WEEK_DAYS   = 7;
  localparam int unsigned WDAY_OFFSET = 3;
  localparam int unsigned WK_NUM_W    = 16;
  localparam int unsigned WK_QUO_W    = 12;

  // Second of day split: 3600 = 16 * 225, 60 = 4 * 15
  localparam int unsigned HOUR_DIV   = 225;
  localparam int unsigned HOUR_NUM_W = 13;
  localparam int unsigned MTOT_DIV   = 15;
  localparam int unsigned MTOT_NUM_W = 15;
  localparam int unsigned MTOT_W     = 11;

  // Calendar
  localparam int unsigned YEAR_BASE  = 1970;
  localparam int unsigned DAYS_1YR   = 365;
  localparam int unsigned DAYS_2YR   = 730;
  localparam int unsigned DAYS_3YR   = 1096;
  localparam int unsigned JAN_DAYS   = 31;
  localparam int unsigned FEB_END    = 59;
  localparam int unsigned JUL_END    = 212;
  localparam int unsigned PAIR_DAYS  = 61;
  localparam int unsigned MON_MAR    = 2;
  localparam int unsigned MON_AUG    = 7;

endpackage

// ===== design/e2c_cdiv.sv =====
// Divide by a constant in three stages: reciprocal multiply, estimate
// remainder, one correction step.
module e2c_cdiv #(
  parameter int unsigned NumW    = e2c_pkg::DAY_NUM_W,
  parameter int unsigned Divisor = e2c_pkg::DAY_DIV,
  parameter int unsigned QuoW    = e2c_pkg::DAYS_W
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [NumW-1:0]              num_i,
  output logic [QuoW-1:0]              quo_o,
  output logic [$clog2(Divisor)-1:0]   rem_o
);

  localparam int unsigned RemW = $clog2(Divisor);
  // floor(2^NumW / Divisor): the estimate is low by at most one
  localparam longint unsigned Recip = (64'd1 << NumW) / Divisor;
  localparam int unsigned RecipW = $clog2(Recip + 1);
  localparam int unsigned ProdW  = NumW + RecipW;

  logic [ProdW-1:0] prod_d, prod_q;
  logic [NumW-1:0]  num_a_q;
  logic [QuoW-1:0]  q0_d, q0_q;
  logic [RemW:0]    r0_d, r0_q;
  logic [QuoW-1:0]  quo_d, quo_q;
  logic [RemW-1:0]  rem_d, rem_q;

  assign prod_d = ProdW'(num_i) * ProdW'(Recip);

  always_comb begin
    q0_d = QuoW'(prod_q >> NumW);
    r0_d = (RemW+1)'(num_a_q - NumW'(NumW'(q0_d) * NumW'(Divisor)));
  end

  always_comb begin
    if (r0_q >= (RemW+1)'(Divisor)) begin
      quo_d = q0_q + QuoW'(1);
      rem_d = RemW'(r0_q - (RemW+1)'(Divisor));
    end else begin
      quo_d = q0_q;
      rem_d = RemW'(r0_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= prod_d;
      num_a_q <= num_i;
      q0_q    <= q0_d;
      r0_q    <= r0_d;
      quo_q   <= quo_d;
      rem_q   <= rem_d;
    end
  end

  assign quo_o = quo_q;
  assign rem_o = rem_q;

endmodule

// ===== design/epoch_to_calendar_fields.sv =====
// Channel   Dir  Word
// s_axis    in   tdata[30:0] epoch_seconds
// m_axis    out  tdata: year, day_of_year, month, day_of_month, weekday,
//                hour, minute, second; tuser: range_error
// cfg       in   cfg_idx_i 0 tz_west_seconds, 1 dst_enable
//
// One word per cycle while the output is not held.
// The pipe holds two rounds of constant division (seconds to days,
// then days and second-of-day), three stages each, plus the offset add
// and three calendar stages. A held output freezes the whole pipe.
// Reset clears the valid bits and both config registers.
module epoch_to_calendar_fields (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [30:0] epoch_seconds, [31] zero
  input  logic [e2c_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [10:0] year, [19:11] day_of_year, [23:20] month, [28:24] day_of_month,
  // [31:29] weekday, [36:32] hour, [42:37] minute, [48:43] second
  output logic [e2c_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // [0] range_error
  output logic                                 m_axis_tuser,
  input  logic                                 cfg_we_i,
  input  logic [e2c_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [e2c_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);
  import e2c_pkg::*;

  localparam int unsigned NStg = 10;
  localparam int unsigned RemW675 = $clog2(DAY_DIV);

  logic                en;
  logic [NStg-1:0]     vld_q, err_q;
  logic [TZ_W-1:0]     tz_q;
  logic                dst_q;

  // Stage 1
  logic [32:0]         adj;
  logic [31:0]         u_q;
  logic [DAY_SHIFT-1:0] lo7_q [3];

  // Stage 4
  logic [DAYS_W-1:0]   days;
  logic [RemW675-1:0]  day_rem;
  logic [SOD_W-1:0]    sod;
  logic [3:0]          sl4_q [3];

  // Stage 7
  logic [CYC_W-1:0]              cyc_quo;
  logic [$clog2(CYCLE_DAYS)-1:0] cyc_rem;
  logic [WK_QUO_W-1:0]           wk_quo;
  logic [WDAY_W-1:0]             wk_rem;
  logic [HOUR_W-1:0]             hr_quo;
  logic [$clog2(HOUR_DIV)-1:0]   hr_rem;
  logic [MTOT_W-1:0]             mt_quo;
  logic [$clog2(MTOT_DIV)-1:0]   mt_rem;

  // Stage 8
  logic [1:0]          yr_off;
  logic [DOY_W-1:0]    doy_d, s8_doy_q;
  logic [YEAR_W-1:0]   year_d, s8_year_q;
  logic                s8_leap_q;
  logic [WDAY_W-1:0]   s8_wday_q;
  logic [HOUR_W-1:0]   s8_hour_q;
  logic [MIN_W-1:0]    min_d, s8_min_q;
  logic [SEC_W-1:0]    sec_d, s8_sec_q;

  // Stage 9
  logic [MONTH_W-1:0]  mon9_d, s9_mon_q;
  logic [DOM_W-1:0]    dom9_d, s9_dom_q;
  logic [7:0]          x9_d, s9_x_q;
  logic                pair9_d, s9_pair_q;
  logic [DOY_W-1:0]    s9_doy_q;
  logic [YEAR_W-1:0]   s9_year_q;
  logic [WDAY_W-1:0]   s9_wday_q;
  logic [HOUR_W-1:0]   s9_hour_q;
  logic [MIN_W-1:0]    s9_min_q;
  logic [SEC_W-1:0]    s9_sec_q;

  // Stage 10
  logic [1:0]          kk;
  logic [7:0]          yy;
  logic [MONTH_W-1:0]  mon_d, o_mon_q;
  logic [DOM_W-1:0]    dom_d, o_dom_q;
  logic [YEAR_W-1:0]   o_year_q;
  logic [DOY_W-1:0]    o_doy_q;
  logic [WDAY_W-1:0]   o_wday_q;
  logic [HOUR_W-1:0]   o_hour_q;
  logic [MIN_W-1:0]    o_min_q;
  logic [SEC_W-1:0]    o_sec_q;

  // Advance unless the output word is held
  assign en            = m_axis_tready || !vld_q[NStg-1];
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tz_q  <= '0;
      dst_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TZ_WEST:    tz_q  <= cfg_wdata_i;
        REG_DST_ENABLE: dst_q <= cfg_wdata_i[0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NStg-2:0], s_axis_tvalid};
    end
  end

  // Exact local time; bit 32 is the sign
  assign adj = {2'b00, s_axis_tdata[EPOCH_W-1:0]}
             - {{(33-TZ_W){tz_q[TZ_W-1]}}, tz_q}
             + (dst_q ? 33'(SECS_HOUR) : 33'd0);

  always_ff @(posedge clk_i) begin
    if (en) begin
      err_q    <= {err_q[NStg-2:0], adj[32]};
      u_q      <= adj[31:0];
      lo7_q[0] <= u_q[DAY_SHIFT-1:0];
      lo7_q[1] <= lo7_q[0];
      lo7_q[2] <= lo7_q[1];
      sl4_q[0] <= sod[3:0];
      sl4_q[1] <= sl4_q[0];
      sl4_q[2] <= sl4_q[1];
    end
  end

  e2c_cdiv #(.NumW(DAY_NUM_W), .Divisor(DAY_DIV), .QuoW(DAYS_W)) u_day (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (u_q[31:DAY_SHIFT]),
    .quo_o (days),
    .rem_o (day_rem)
  );

  assign sod = {day_rem, lo7_q[2]};

  e2c_cdiv #(.NumW(DAYS_W), .Divisor(CYCLE_DAYS), .QuoW(CYC_W)) u_cyc (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (days),
    .quo_o (cyc_quo),
    .rem_o (cyc_rem)
  );

  e2c_cdiv #(.NumW(WK_NUM_W), .Divisor(WEEK_DAYS), .QuoW(WK_QUO_W)) u_wk (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (WK_NUM_W'(days) + WK_NUM_W'(WDAY_OFFSET)),
    .quo_o (wk_quo),
    .rem_o (wk_rem)
  );

  e2c_cdiv #(.NumW(HOUR_NUM_W), .Divisor(HOUR_DIV), .QuoW(HOUR_W)) u_hour (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (sod[SOD_W-1:4]),
    .quo_o (hr_quo),
    .rem_o (hr_rem)
  );

  e2c_cdiv #(.NumW(MTOT_NUM_W), .Divisor(MTOT_DIV), .QuoW(MTOT_W)) u_mtot (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (sod[SOD_W-1:2]),
    .quo_o (mt_quo),
    .rem_o (mt_rem)
  );

  // Stage 8: year within the four-year cycle, minute and second
  always_comb begin
    priority if (cyc_rem < 11'(DAYS_1YR)) begin
      yr_off = 2'd0;
      doy_d  = DOY_W'(cyc_rem);
    end else if (cyc_rem < 11'(DAYS_2YR)) begin
      yr_off = 2'd1;
      doy_d  = DOY_W'(cyc_rem - 11'(DAYS_1YR));
    end else if (cyc_rem < 11'(DAYS_3YR)) begin
      yr_off = 2'd2;
      doy_d  = DOY_W'(cyc_rem - 11'(DAYS_2YR));
    end else begin
      yr_off = 2'd3;
      doy_d  = DOY_W'(cyc_rem - 11'(DAYS_3YR));
    end
    year_d = YEAR_W'(YEAR_BASE) + YEAR_W'({cyc_quo, 2'b00}) + YEAR_W'(yr_off);
    min_d  = MIN_W'(mt_quo - MTOT_W'(MTOT_W'(hr_quo) * MTOT_W'(60)));
    sec_d  = {mt_rem, sl4_q[2][1:0]};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_year_q <= year_d;
      s8_doy_q  <= doy_d;
      s8_leap_q <= (yr_off == 2'd2);
      s8_wday_q <= wk_rem;
      s8_hour_q <= hr_quo;
      s8_min_q  <= min_d;
      s8_sec_q  <= sec_d;
    end
  end

  // Stage 9: January, February, or offset into a run of month pairs
  always_comb begin
    mon9_d  = '0;
    dom9_d  = '0;
    x9_d    = '0;
    pair9_d = 1'b0;
    priority if (s8_doy_q < DOY_W'(JAN_DAYS)) begin
      dom9_d = DOM_W'(s8_doy_q + DOY_W'(1));
    end else if (s8_doy_q < DOY_W'(FEB_END) + DOY_W'(s8_leap_q)) begin
      mon9_d = MONTH_W'(1);
      dom9_d = DOM_W'(s8_doy_q - DOY_W'(JAN_DAYS - 1));
    end else if (s8_doy_q < DOY_W'(JUL_END) + DOY_W'(s8_leap_q)) begin
      mon9_d  = MONTH_W'(MON_MAR);
      x9_d    = 8'(s8_doy_q - DOY_W'(FEB_END) - DOY_W'(s8_leap_q));
      pair9_d = 1'b1;
    end else begin
      mon9_d  = MONTH_W'(MON_AUG);
      x9_d    = 8'(s8_doy_q - DOY_W'(JUL_END) - DOY_W'(s8_leap_q));
      pair9_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s9_mon_q  <= mon9_d;
      s9_dom_q  <= dom9_d;
      s9_x_q    <= x9_d;
      s9_pair_q <= pair9_d;
      s9_year_q <= s8_year_q;
      s9_doy_q  <= s8_doy_q;
      s9_wday_q <= s8_wday_q;
      s9_hour_q <= s8_hour_q;
      s9_min_q  <= s8_min_q;
      s9_sec_q  <= s8_sec_q;
    end
  end

  // Stage 10: pick the pair, then the month inside it
  always_comb begin
    priority if (s9_x_q >= 8'(2 * PAIR_DAYS)) begin
      kk = 2'd2;
      yy = s9_x_q - 8'(2 * PAIR_DAYS);
    end else if (s9_x_q >= 8'(PAIR_DAYS)) begin
      kk = 2'd1;
      yy = s9_x_q - 8'(PAIR_DAYS);
    end else begin
      kk = 2'd0;
      yy = s9_x_q;
    end
    if (!s9_pair_q) begin
      mon_d = s9_mon_q;
      dom_d = s9_dom_q;
    end else if (yy >= 8'(JAN_DAYS)) begin
      mon_d = s9_mon_q + MONTH_W'({kk, 1'b1});
      dom_d = DOM_W'(yy - 8'(JAN_DAYS - 1));
    end else begin
      mon_d = s9_mon_q + MONTH_W'({kk, 1'b0});
      dom_d = DOM_W'(yy + 8'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (err_q[NStg-2]) begin
        o_year_q <= '0;
        o_doy_q  <= '0;
        o_mon_q  <= '0;
        o_dom_q  <= '0;
        o_wday_q <= '0;
        o_hour_q <= '0;
        o_min_q  <= '0;
        o_sec_q  <= '0;
      end else begin
        o_year_q <= s9_year_q;
        o_doy_q  <= s9_doy_q;
        o_mon_q  <= mon_d;
        o_dom_q  <= dom_d;
        o_wday_q <= s9_wday_q;
        o_hour_q <= s9_hour_q;
        o_min_q  <= s9_min_q;
        o_sec_q  <= s9_sec_q;
      end
    end
  end

  assign m_axis_tvalid = vld_q[NStg-1];
  assign m_axis_tuser  = err_q[NStg-1];
  assign m_axis_tdata  = {7'b0, o_sec_q, o_min_q, o_hour_q, o_wday_q, o_dom_q,
                          o_mon_q, o_doy_q, o_year_q};

  // Weekday and four-year split come from the same day count
  a_wk_matches_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[6] |-> (32'(wk_quo) * 32'd7 + 32'(wk_rem)
                  == 32'(cyc_quo) * 32'd1461 + 32'(cyc_rem) + 32'd3))
    else $error("weekday and cycle split disagree");

  // Hour split and minute split come from the same second of day
  a_hour_matches_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[6] |-> (32'(hr_quo) * 32'd3600 + 32'({hr_rem, sl4_q[2]})
                  == 32'(mt_quo) * 32'd60 + 32'({mt_rem, sl4_q[2][1:0]})))
    else $error("hour and minute split disagree");

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(vld_q))
    else $error("pipeline moved while output held");

  a_field_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |->
      (o_mon_q <= 4'd11 && o_dom_q != 5'd0 && o_wday_q <= 3'd6 &&
       o_hour_q <= 5'd23 && o_min_q <= 6'd59 && o_sec_q <= 6'd59))
    else $error("calendar field out of range");

  a_err_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("range error word carries data");

endmodule

// ===== tb/tb_epoch_to_calendar_fields.sv =====
module tb_epoch_to_calendar_fields;
  import e2c_pkg::*;

  typedef struct {
    logic [YEAR_W-1:0]  year;
    logic [DOY_W-1:0]   yday;
    logic [MONTH_W-1:0] month;
    logic [DOM_W-1:0]   mday;
    logic [WDAY_W-1:0]  wday;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
    logic               range_err;
  } cal_t;

  localparam longint EPOCH_MAX = 64'h7FFF_FFFF;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i = '0;

  // Local copy of the offset registers
  logic signed [TZ_W-1:0] tz_west_q = '0;
  logic                   dst_q = 1'b0;

  logic [EPOCH_W-1:0] epoch_q[$];
  cal_t               date_q[$];
  int unsigned        mismatch_count = 0;
  int unsigned        send_gap = 0, send_calm = 0;
  int unsigned        recv_gap = 0, recv_calm = 0;

  int unsigned directed_epochs[23] = '{
    0, 1, 59, 60, 3599, 86399, 86400,
    5011200, 5097600,             // Feb 28 / Mar 1, common year
    18230400, 18316800,           // Jul 31 / Aug 1
    31535999, 31536000, 63071999, 63072000,
    68169600, 68256000,           // Feb 29 / Mar 1, leap year
    94608000, 94694400,           // Dec 31 of leap year / next Jan 1
    126230399, 126230400,         // four-year cycle rollover
    951782400, 32'h7FFF_FFFF
  };

  epoch_to_calendar_fields u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic cal_t civil_fields_of(logic [EPOCH_W-1:0] epoch);
    cal_t   f;
    longint t, cyc, rem, dcyc, yr, yd, lp, x, mon, dom;
    f = '{default: '0};
    t = longint'(epoch) - longint'(tz_west_q) + 3600 * longint'(dst_q);
    if (t < 0) begin
      f.range_err = 1'b1;
      return f;
    end
    cyc  = t / 126230400;
    rem  = t % 126230400;
    dcyc = rem / 86400;
    // cycle starts 1970: two common years, leap 1972, then 1973
    if (dcyc < 730) begin
      yr = cyc * 4 + rem / 31536000 + 1970;
      yd = dcyc % 365;
    end else if (dcyc < 1096) begin
      yr = cyc * 4 + 1972;
      yd = dcyc - 730;
    end else begin
      yr = cyc * 4 + 1973;
      yd = dcyc - 1096;
    end
    lp = ((yr - 1968) % 4 == 0) ? 1 : 0;
    if (yd < 31) begin
      mon = 0;
      dom = yd + 1;
    end else if (yd < 59 + lp) begin
      mon = 1;
      dom = yd - 30;
    end else begin
      // 61-day month pairs from March and from August
      if (yd < 212 + lp) begin
        mon = 2;
        x = yd - 59 - lp;
      end else begin
        mon = 7;
        x = yd - 212 - lp;
      end
      mon = mon + (x / 61) * 2 + (x % 61) / 31;
      dom = (x % 61) % 31 + 1;
    end
    f.year   = yr[YEAR_W-1:0];
    f.yday   = yd[DOY_W-1:0];
    f.month  = mon[MONTH_W-1:0];
    f.mday   = dom[DOM_W-1:0];
    x        = (t / 86400 + 3) % 7;
    f.wday   = x[WDAY_W-1:0];
    x        = (t / 3600) % 24;
    f.hour   = x[HOUR_W-1:0];
    x        = (t / 60) % 60;
    f.minute = x[MIN_W-1:0];
    x        = t % 60;
    f.second = x[SEC_W-1:0];
    return f;
  endfunction

  // Mostly no gap, some short, a few long; calm stretches with no gap at all
  function automatic int unsigned next_gap(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(30, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Driver: hold the word until accepted, then optionally idle
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        date_q.push_back(civil_fields_of(s_axis_tdata[EPOCH_W-1:0]));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (epoch_q.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {1'b0, epoch_q.pop_front()};
          send_gap = next_gap(send_calm);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure, compare each word against the oldest date
  always @(posedge clk_i) begin
    cal_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.year      = m_axis_tdata[10:0];
      got.yday      = m_axis_tdata[19:11];
      got.month     = m_axis_tdata[23:20];
      got.mday      = m_axis_tdata[28:24];
      got.wday      = m_axis_tdata[31:29];
      got.hour      = m_axis_tdata[36:32];
      got.minute    = m_axis_tdata[42:37];
      got.second    = m_axis_tdata[48:43];
      got.range_err = m_axis_tuser;
      if (date_q.size() == 0) begin
        $error("output word with no date expected");
        mismatch_count++;
      end else begin
        want = date_q.pop_front();
        check_field("year", want.year, got.year);
        check_field("day_of_year", want.yday, got.yday);
        check_field("month", want.month, got.month);
        check_field("day_of_month", want.mday, got.mday);
        check_field("weekday", want.wday, got.wday);
        check_field("hour", want.hour, got.hour);
        check_field("minute", want.minute, got.minute);
        check_field("second", want.second, got.second);
        check_field("range_error", want.range_err, got.range_err);
      end
    end
    if (recv_gap > 0) begin
      recv_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      recv_gap = next_gap(recv_calm);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_TZ_WEST) tz_west_q = data;
    else dst_q = data[0];
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (epoch_q.size() != 0 || s_axis_tvalid || date_q.size() != 0)
      @(negedge clk_i);
  endtask

  // Epoch value that lands the local time at t, if representable
  task automatic push_local(longint t);
    longint e;
    e = t + longint'(tz_west_q) - 3600 * longint'(dst_q);
    if (e >= 0 && e <= EPOCH_MAX) epoch_q.push_back(e[EPOCH_W-1:0]);
  endtask

  task automatic add_random_items(int n);
    int     k, sel, y;
    longint days, t;
    int     marks[11] = '{0, 30, 31, 58, 59, 60, 211, 212, 213, 364, 365};
    for (k = 0; k < n; k++) begin
      sel = $urandom_range(0, 9);
      if (sel < 5) begin
        epoch_q.push_back(EPOCH_W'($urandom()));
      end else if (sel < 8) begin
        // land near a year, month or leap-day boundary in local time
        y    = $urandom_range(1970, 2037);
        days = 365 * (y - 1970) + (y - 1969) / 4 + marks[$urandom_range(0, 10)];
        t    = days * 86400 + $urandom_range(0, 3) - 2;
        push_local(t);
      end else begin
        epoch_q.push_back(EPOCH_W'($urandom_range(0, 200000)));
      end
    end
  endtask

  initial begin
    int p, d;
    logic [TZ_W-1:0] tz_set[6] = '{17'h0_0000, 17'd43200, -17'sd50400,
                                    17'h0_FFFF, 17'h1_0000, 17'h0_0000};
    logic            dst_set[6] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (p = 0; p < 6; p++) begin
      if (p > 0) begin
        wait_drained();
        if (p == 5) begin
          tz_set[p]  = TZ_W'($urandom());
          dst_set[p] = 1'($urandom_range(0, 1));
        end
        write_reg(REG_TZ_WEST, tz_set[p]);
        // upper data bits are don't-care for the flag
        write_reg(REG_DST_ENABLE, {16'($urandom_range(0, 65535)), dst_set[p]});
      end
      if (p == 0) begin
        foreach (directed_epochs[i]) epoch_q.push_back(directed_epochs[i][EPOCH_W-1:0]);
        add_random_items(100);
      end else begin
        // straddle local midnight of 1970-01-01 and the upper end of time
        for (d = -2; d <= 2; d++) push_local(d);
        epoch_q.push_back(EPOCH_MAX[EPOCH_W-1:0]);
        add_random_items(135);
      end
    end
    wait_drained();
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0 && date_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(8 * 400000);
    $display("FAIL");
    $finish;
  end

endmodule
